// ===== rtl/glzw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// glzw_pkg
// Shared types and constants of the GIF LZW decoder: operation and result
// codes, configuration register indexes and the controller/datapath links.
// ============================================================================
package glzw_pkg;

    localparam int CODE_W   = 12;
    localparam int CMP_W    = CODE_W + 1;
    localparam int ACC_W    = 24;
    localparam int COUNT_W  = 5;
    localparam int WIDTH_W  = 4;
    localparam int PIX_W    = 8;
    localparam int TOTAL_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int ROOT_CW  = 9;

    localparam logic [WIDTH_W-1:0] ROOT_MIN   = 4'd2;
    localparam logic [WIDTH_W-1:0] ROOT_MAX   = 4'd8;
    localparam logic [WIDTH_W-1:0] ROOT_RESET = 4'd8;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH  = 4'd12;
    localparam logic [COUNT_W-1:0] ACC_LIMIT  = 5'd16;
    localparam logic [COUNT_W-1:0] BYTE_BITS  = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PIXELS = 2'd1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PUSH  = 2'd1,
        OP_PULL  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_NEED_BYTE = 3'd1,
        ST_COMPLETE  = 3'd2,
        ST_ENDED     = 3'd3,
        ST_ACCEPTED  = 3'd4,
        ST_REFUSED   = 3'd5,
        ST_STARTED   = 3'd6
    } t_status;

    typedef struct packed {
        logic    start;
        logic    push;
        logic    fetch;
        logic    restart;
        logic    stop;
        logic    first_code;
        logic    decode;
        logic    walk;
        logic    tail;
        logic    set_pend;
        t_status pend;
        logic    res_load;
        logic    pop;
    } t_dp_cmd;

    typedef struct packed {
        logic img_done;
        logic stack_empty;
        logic push_refused;
        logic stopped;
        logic short_bits;
        logic input_done;
        logic bad_code;
        logic clear_code;
        logic prev_valid;
        logic code_high;
        logic walk_go;
        logic pend_pixel;
    } t_dp_stat;

endpackage

// ===== rtl/gif_lzw_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gif_lzw_decoder
// GIF variable-width LZW decoder: start, push compressed bytes, pull pixels.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  input     i_valid / o_ready         i_op, i_data_byte, i_final_byte
//  output    o_valid / i_ready         o_pixel, o_status
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Start, push, and a pull served from a non-empty stack go from idle
//  straight to the response state. A pull on an empty stack fetches codes
//  (clear codes included) and walks the dictionary chain symbol by symbol.
//  Synchronous active-low reset; memories are not cleared.
//  A result waits in the output register; the next beat is taken meanwhile
//  and its result is held until the register frees.
//
module gif_lzw_decoder #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [glzw_pkg::PIX_W-1:0]     i_data_byte,
    input  logic                           i_final_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [glzw_pkg::PIX_W-1:0]     o_pixel,
    output logic [2:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [glzw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [glzw_pkg::TOTAL_W-1:0]   i_cfg_data
);

    glzw_pkg::t_dp_cmd  cmd;
    glzw_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    glzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    glzw_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_pixel      (o_pixel),
        .o_status     (o_status)
    );

endmodule

// ===== rtl/glzw_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// glzw_dp
// Datapath: bit accumulator, code extraction, dictionary and string stack
// memories, decoder state registers and the result register.
// ============================================================================
module glzw_dp #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [glzw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [glzw_pkg::TOTAL_W-1:0]        i_cfg_data,
    input  logic [glzw_pkg::PIX_W-1:0]          i_data_byte,
    input  logic                                i_final_byte,
    input  glzw_pkg::t_dp_cmd                   i_cmd,
    output glzw_pkg::t_dp_stat                  o_stat,
    output logic [glzw_pkg::PIX_W-1:0]          o_pixel,
    output logic [2:0]                          o_status
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int DW = IW + 1;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(TABLE_ENTRIES);
    localparam logic [DW-1:0] NF_RESET  = DW'((32'd1 << glzw_pkg::ROOT_RESET) + 32'd2);
    localparam logic [glzw_pkg::WIDTH_W-1:0] WIDTH_RESET = glzw_pkg::ROOT_RESET + 4'd1;

    // Memories
    logic [glzw_pkg::CODE_W-1:0] mem_prefix [TABLE_ENTRIES];
    logic [glzw_pkg::PIX_W-1:0]  mem_suffix [TABLE_ENTRIES];
    logic [glzw_pkg::PIX_W-1:0]  mem_stack  [TABLE_ENTRIES];

    // Registers
    logic [glzw_pkg::WIDTH_W-1:0] r_root,  n_root;
    logic [glzw_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [DW-1:0]                r_depth, n_depth;
    logic [glzw_pkg::ACC_W-1:0]   r_acc,   n_acc;
    logic [glzw_pkg::COUNT_W-1:0] r_count, n_count;
    logic [glzw_pkg::WIDTH_W-1:0] r_width, n_width;
    logic [DW-1:0]                r_next_free, n_next_free;
    logic [glzw_pkg::CODE_W-1:0]  r_prev, n_prev;
    logic                         r_prev_valid, n_prev_valid;
    logic [glzw_pkg::PIX_W-1:0]   r_first, n_first;
    logic [glzw_pkg::TOTAL_W-1:0] r_pixels, n_pixels;
    logic                         r_input_done, n_input_done;
    logic                         r_stopped, n_stopped;
    logic [glzw_pkg::CODE_W-1:0]  r_cur, n_cur;
    logic [glzw_pkg::CODE_W-1:0]  r_code, n_code;
    glzw_pkg::t_status            r_pend, n_pend;
    glzw_pkg::t_status            r_out_status, n_out_status;
    logic [glzw_pkg::PIX_W-1:0]   r_out_pixel, n_out_pixel;
    logic [glzw_pkg::CODE_W-1:0]  r_rd_prefix;
    logic [glzw_pkg::PIX_W-1:0]   r_rd_suffix;
    logic [glzw_pkg::PIX_W-1:0]   r_rd_stack;

    // Decode logic
    logic [glzw_pkg::WIDTH_W-1:0] eff_root;
    logic [glzw_pkg::ROOT_CW-1:0] clear_code;
    logic [glzw_pkg::CODE_W-1:0]  clear12, end12;
    logic [glzw_pkg::CODE_W-1:0]  mask, code, cur0, cur_sel;
    logic [glzw_pkg::CMP_W-1:0]   code13, nf13;
    logic                         kwkwk;
    logic                         push_req, push_do;
    logic [glzw_pkg::PIX_W-1:0]   push_val;
    logic [DW-1:0]                depth_after, depth_m1, nf_inc;
    logic                         tab_we, widen;

    always_comb begin
        if (r_root < glzw_pkg::ROOT_MIN) begin
            eff_root = glzw_pkg::ROOT_MIN;
        end else if (r_root > glzw_pkg::ROOT_MAX) begin
            eff_root = glzw_pkg::ROOT_MAX;
        end else begin
            eff_root = r_root;
        end
    end

    assign clear_code = glzw_pkg::ROOT_CW'(1) << eff_root;
    assign clear12    = glzw_pkg::CODE_W'(clear_code);
    assign end12      = clear12 + glzw_pkg::CODE_W'(1);
    assign mask       = ~({glzw_pkg::CODE_W{1'b1}} << r_width);
    assign code       = r_acc[glzw_pkg::CODE_W-1:0] & mask;
    assign code13     = glzw_pkg::CMP_W'(code);
    assign nf13       = glzw_pkg::CMP_W'(r_next_free);
    assign kwkwk      = (code13 == nf13);
    assign cur0       = kwkwk ? r_prev : code;
    // During a chain walk the next address comes straight from the prefix just read.
    assign cur_sel    = i_cmd.walk ? r_rd_prefix : cur0;

    always_comb begin
        push_req = 1'b0;
        push_val = '0;
        if (i_cmd.first_code) begin
            push_req = 1'b1;
            push_val = code[glzw_pkg::PIX_W-1:0];
        end else if (i_cmd.decode && kwkwk) begin
            push_req = 1'b1;
            push_val = r_first;
        end else if (i_cmd.walk) begin
            push_req = 1'b1;
            push_val = r_rd_suffix;
        end else if (i_cmd.tail) begin
            push_req = 1'b1;
            push_val = r_cur[glzw_pkg::PIX_W-1:0];
        end
    end

    assign push_do     = push_req && (r_depth < DEPTH_MAX);
    assign depth_after = push_do ? r_depth + DW'(1) : r_depth;
    assign depth_m1    = r_depth - DW'(1);
    assign nf_inc      = r_next_free + DW'(1);
    assign tab_we      = i_cmd.tail && (r_next_free < DEPTH_MAX);
    assign widen       = ((glzw_pkg::CODE_W'(nf_inc) & mask) == '0)
                         && (nf_inc < DEPTH_MAX) && (r_width < glzw_pkg::MAX_WIDTH);

    always_comb begin
        o_stat.img_done     = (r_pixels >= r_total);
        o_stat.stack_empty  = (r_depth == '0);
        o_stat.push_refused = r_input_done || (r_count > glzw_pkg::ACC_LIMIT);
        o_stat.stopped      = r_stopped;
        o_stat.short_bits   = (glzw_pkg::COUNT_W'(r_width) > r_count);
        o_stat.input_done   = r_input_done;
        o_stat.bad_code     = (code == end12) || (code13 > nf13);
        o_stat.clear_code   = (code == clear12);
        o_stat.prev_valid   = r_prev_valid;
        o_stat.code_high    = (code >= clear12);
        o_stat.walk_go      = (cur_sel >= clear12)
                              && (glzw_pkg::CMP_W'(cur_sel) < glzw_pkg::CMP_W'(TABLE_ENTRIES))
                              && (depth_after < DEPTH_MAX);
        o_stat.pend_pixel   = (r_pend == glzw_pkg::ST_PIXEL);
    end

    always_comb begin
        n_root = r_root;
        n_total = r_total;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                glzw_pkg::CFG_ROOT_BITS:    n_root  = i_cfg_data[glzw_pkg::WIDTH_W-1:0];
                glzw_pkg::CFG_TOTAL_PIXELS: n_total = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_depth      = push_do ? r_depth + DW'(1) : r_depth;
        n_acc        = r_acc;
        n_count      = r_count;
        n_width      = r_width;
        n_next_free  = r_next_free;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_first      = r_first;
        n_pixels     = r_pixels;
        n_input_done = r_input_done;
        n_stopped    = r_stopped;
        n_cur        = r_cur;
        n_code       = r_code;
        n_pend       = r_pend;
        n_out_status = r_out_status;
        n_out_pixel  = r_out_pixel;

        if (i_cmd.pop) begin
            n_depth  = depth_m1;
            n_pixels = r_pixels + glzw_pkg::TOTAL_W'(1);
        end
        if (i_cmd.push) begin
            n_acc   = r_acc | (glzw_pkg::ACC_W'(i_data_byte) << r_count);
            n_count = r_count + glzw_pkg::BYTE_BITS;
            if (i_final_byte) begin
                n_input_done = 1'b1;
            end
        end
        if (i_cmd.fetch) begin
            n_acc   = r_acc >> r_width;
            n_count = r_count - glzw_pkg::COUNT_W'(r_width);
        end
        if (i_cmd.stop) begin
            n_stopped = 1'b1;
        end
        if (i_cmd.first_code) begin
            n_prev       = code;
            n_first      = code[glzw_pkg::PIX_W-1:0];
            n_prev_valid = 1'b1;
        end
        if (i_cmd.decode) begin
            n_cur  = cur_sel;
            n_code = code;
        end
        if (i_cmd.walk) begin
            n_cur = cur_sel;
        end
        if (i_cmd.tail) begin
            n_first = r_cur[glzw_pkg::PIX_W-1:0];
            n_prev  = r_code;
            if (tab_we) begin
                n_next_free = nf_inc;
                if (widen) begin
                    n_width = r_width + 4'd1;
                end
            end
        end
        if (i_cmd.restart || i_cmd.start) begin
            n_width      = eff_root + 4'd1;
            n_next_free  = DW'(clear_code) + DW'(2);
            n_prev_valid = 1'b0;
        end
        if (i_cmd.start) begin
            n_depth      = '0;
            n_acc        = '0;
            n_count      = '0;
            n_prev       = '0;
            n_first      = '0;
            n_pixels     = '0;
            n_input_done = 1'b0;
            n_stopped    = 1'b0;
        end
        if (i_cmd.set_pend) begin
            n_pend = i_cmd.pend;
        end
        if (i_cmd.res_load) begin
            n_out_status = r_pend;
            n_out_pixel  = (r_pend == glzw_pkg::ST_PIXEL) ? r_rd_stack : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= glzw_pkg::ROOT_RESET;
            r_total      <= '0;
            r_depth      <= '0;
            r_acc        <= '0;
            r_count      <= '0;
            r_width      <= WIDTH_RESET;
            r_next_free  <= NF_RESET;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_first      <= '0;
            r_pixels     <= '0;
            r_input_done <= 1'b0;
            r_stopped    <= 1'b0;
        end else begin
            r_root       <= n_root;
            r_total      <= n_total;
            r_depth      <= n_depth;
            r_acc        <= n_acc;
            r_count      <= n_count;
            r_width      <= n_width;
            r_next_free  <= n_next_free;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_first      <= n_first;
            r_pixels     <= n_pixels;
            r_input_done <= n_input_done;
            r_stopped    <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_code       <= n_code;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_pixel  <= n_out_pixel;
    end

    // Dictionary: one entry added per decoded code after the first while not full; read at the chain address.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            mem_prefix[r_next_free[IW-1:0]] <= r_prev;
            mem_suffix[r_next_free[IW-1:0]] <= r_cur[glzw_pkg::PIX_W-1:0];
        end
        r_rd_prefix <= mem_prefix[cur_sel[IW-1:0]];
        r_rd_suffix <= mem_suffix[cur_sel[IW-1:0]];
    end

    // The stack is always read at its top, so the next pixel is registered ahead of the result register.
    always_ff @(posedge i_clk) begin
        if (push_do) begin
            mem_stack[r_depth[IW-1:0]] <= push_val;
        end
        r_rd_stack <= mem_stack[depth_m1[IW-1:0]];
    end

    assign o_pixel  = r_out_pixel;
    assign o_status = r_out_status;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("string stack depth beyond its size");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_depth != '0) && (r_pend == glzw_pkg::ST_PIXEL))
        else $error("pixel popped from an empty stack");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= 4'd3) && (r_width <= glzw_pkg::MAX_WIDTH))
        else $error("code width out of range");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail && (r_next_free == DEPTH_MAX) |=> (r_next_free == DEPTH_MAX))
        else $error("dictionary grew past its size");
`endif

endmodule

// ===== rtl/glzw_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// glzw_ctrl
// Controller: takes input beats, sequences code fetch, chain walk and stack
// pop, and hands results to the output register.
// ============================================================================
module glzw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    output logic                o_valid,
    input  logic                i_ready,
    input  glzw_pkg::t_dp_stat  i_stat,
    output glzw_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_WALK  = 6'b000100,
        S_TAIL  = 6'b001000,
        S_POP   = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.set_pend = 1'b1;
                    n_state = S_RESP;
                    unique case (i_op)
                        glzw_pkg::OP_START: begin
                            o_cmd.start = 1'b1;
                            o_cmd.pend  = glzw_pkg::ST_STARTED;
                        end
                        glzw_pkg::OP_PUSH: begin
                            if (i_stat.push_refused) begin
                                o_cmd.pend = glzw_pkg::ST_REFUSED;
                            end else begin
                                o_cmd.push = 1'b1;
                                o_cmd.pend = glzw_pkg::ST_ACCEPTED;
                            end
                        end
                        glzw_pkg::OP_PULL: begin
                            priority if (i_stat.img_done) begin
                                o_cmd.pend = glzw_pkg::ST_COMPLETE;
                            end else if (!i_stat.stack_empty) begin
                                o_cmd.pend = glzw_pkg::ST_PIXEL;
                            end else begin
                                o_cmd.set_pend = 1'b0;
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            o_cmd.pend = glzw_pkg::ST_REFUSED;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.set_pend = 1'b1;
                o_cmd.pend     = glzw_pkg::ST_ENDED;
                n_state        = S_RESP;
                priority if (i_stat.stopped) begin
                    o_cmd.pend = glzw_pkg::ST_ENDED;
                end else if (i_stat.short_bits) begin
                    // Leftover bits after the final byte are padding.
                    if (i_stat.input_done) begin
                        o_cmd.stop = 1'b1;
                    end else begin
                        o_cmd.pend = glzw_pkg::ST_NEED_BYTE;
                    end
                end else begin
                    o_cmd.fetch = 1'b1;
                    priority if (i_stat.bad_code) begin
                        o_cmd.stop = 1'b1;
                    end else if (i_stat.clear_code) begin
                        o_cmd.restart  = 1'b1;
                        o_cmd.set_pend = 1'b0;
                        n_state        = S_FETCH;
                    end else if (!i_stat.prev_valid) begin
                        if (i_stat.code_high) begin
                            o_cmd.stop = 1'b1;
                        end else begin
                            o_cmd.first_code = 1'b1;
                            o_cmd.pend       = glzw_pkg::ST_PIXEL;
                            n_state          = S_POP;
                        end
                    end else begin
                        o_cmd.decode = 1'b1;
                        o_cmd.pend   = glzw_pkg::ST_PIXEL;
                        n_state      = i_stat.walk_go ? S_WALK : S_TAIL;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                n_state    = i_stat.walk_go ? S_WALK : S_TAIL;
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_POP;
            end
            S_POP: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.pop      = i_stat.pend_pixel;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat taken while one is in flight");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("result shown outside the response state");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the GIF LZW decoder. Code streams are packed at the
// widths the decoder will use and fed as push beats mixed with pull beats.
// Every accepted beat is run through an in-bench decoder, and each result
// beat is compared with the oldest answer still owed.
// ============================================================================
module tb;
    import glzw_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam longint RUN_LIMIT_NS = 20_000_000;
    // The op field is two bits wide; the top encoding is not an operation.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        t_status          status;
    } decode_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_op;
    logic [PIX_W-1:0]     i_data_byte;
    logic                 i_final_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic [PIX_W-1:0]     o_pixel;
    logic [2:0]           o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TOTAL_W-1:0]   i_cfg_data;

    gif_lzw_decoder #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_final_byte(i_final_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel     (o_pixel),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // In-bench decoder state
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] root_cfg;
    logic [TOTAL_W-1:0] total_cfg;
    logic [CODE_W-1:0]  prefix_mem [TABLE_DEPTH];
    logic [PIX_W-1:0]   suffix_mem [TABLE_DEPTH];
    logic [PIX_W-1:0]   sym_stack  [TABLE_DEPTH];
    logic [CMP_W-1:0]   sym_depth;
    logic [ACC_W-1:0]   acc_bits;
    logic [COUNT_W-1:0] acc_count;
    logic [WIDTH_W-1:0] code_width;
    logic [CMP_W-1:0]   next_free;
    logic [CODE_W-1:0]  prev_code;
    logic               prev_valid;
    logic [PIX_W-1:0]   first_sym;
    logic [TOTAL_W-1:0] pix_done;
    logic               in_done;
    logic               stopped;

    decode_result_t owed_answers[$];
    int             error_count;
    int             items_sent;
    int             burst_left;

    // Encoder side: mirrors the dictionary growth to know each code's width.
    int unsigned enc_root;
    int unsigned enc_clear;
    int unsigned enc_width;
    int unsigned enc_next;
    bit          enc_live;
    logic [31:0] enc_acc;
    int unsigned enc_bits;
    logic [7:0]  stream_bytes[$];

    function automatic int unsigned clamp_root(input logic [WIDTH_W-1:0] r);
        if (r < ROOT_MIN) return ROOT_MIN;
        if (r > ROOT_MAX) return ROOT_MAX;
        return r;
    endfunction

    function automatic void restart_dict();
        code_width = WIDTH_W'(clamp_root(root_cfg) + 1);
        next_free  = CMP_W'((1 << clamp_root(root_cfg)) + 2);
        prev_valid = 1'b0;
    endfunction

    function automatic void start_image();
        sym_depth = '0;
        acc_bits  = '0;
        acc_count = '0;
        prev_code = '0;
        first_sym = '0;
        pix_done  = '0;
        in_done   = 1'b0;
        stopped   = 1'b0;
        restart_dict();
    endfunction

    function automatic void push_symbol(input logic [PIX_W-1:0] s);
        if (sym_depth < TABLE_DEPTH) begin
            sym_stack[sym_depth] = s;
            sym_depth++;
        end
    endfunction

    // Reads codes until the stack holds symbols, more input is needed,
    // or the stream stops.
    function automatic t_status fetch_symbols();
        int unsigned clear_c;
        int unsigned code;
        int unsigned cur;
        while (1'b1) begin
            if (stopped) return ST_ENDED;
            if (acc_count < code_width) begin
                if (in_done) begin
                    stopped = 1'b1;
                    return ST_ENDED;
                end
                return ST_NEED_BYTE;
            end
            code      = acc_bits & ((1 << code_width) - 1);
            acc_bits  = acc_bits >> code_width;
            acc_count = acc_count - code_width;
            clear_c   = 1 << clamp_root(root_cfg);
            if (code == clear_c + 1 || code > next_free) begin
                stopped = 1'b1;
                return ST_ENDED;
            end
            if (code == clear_c) begin
                restart_dict();
                continue;
            end
            if (!prev_valid) begin
                if (code >= clear_c) begin
                    stopped = 1'b1;
                    return ST_ENDED;
                end
                push_symbol(PIX_W'(code));
                prev_code  = CODE_W'(code);
                first_sym  = PIX_W'(code);
                prev_valid = 1'b1;
                return ST_PIXEL;
            end
            cur = code;
            // A code one past the dictionary repeats the previous string
            // followed by its own first symbol.
            if (code == next_free) begin
                push_symbol(first_sym);
                cur = prev_code;
            end
            while (cur >= clear_c && cur < TABLE_DEPTH && sym_depth < TABLE_DEPTH) begin
                push_symbol(suffix_mem[cur]);
                cur = prefix_mem[cur];
            end
            first_sym = PIX_W'(cur);
            push_symbol(first_sym);
            if (next_free < TABLE_DEPTH) begin
                prefix_mem[next_free] = prev_code;
                suffix_mem[next_free] = first_sym;
                next_free++;
                if ((int'(next_free) & ((1 << code_width) - 1)) == 0
                        && next_free < TABLE_DEPTH && code_width < MAX_WIDTH)
                    code_width++;
            end
            prev_code = CODE_W'(code);
            return ST_PIXEL;
        end
        return ST_ENDED;
    endfunction

    function automatic decode_result_t decode_item(input logic [1:0] op,
                                                   input logic [PIX_W-1:0] data,
                                                   input logic fin);
        decode_result_t res;
        t_status        fr;
        res.pixel  = '0;
        res.status = ST_REFUSED;
        case (op)
            OP_START: begin
                start_image();
                res.status = ST_STARTED;
            end
            OP_PUSH: begin
                if (!in_done && acc_count <= ACC_LIMIT) begin
                    acc_bits  = acc_bits | (ACC_W'(data) << acc_count);
                    acc_count = acc_count + BYTE_BITS;
                    if (fin) in_done = 1'b1;
                    res.status = ST_ACCEPTED;
                end
            end
            OP_PULL: begin
                if (pix_done >= total_cfg) begin
                    res.status = ST_COMPLETE;
                end else begin
                    fr = ST_PIXEL;
                    if (sym_depth == 0) fr = fetch_symbols();
                    if (fr == ST_PIXEL && sym_depth > 0) begin
                        sym_depth--;
                        res.pixel  = sym_stack[sym_depth];
                        pix_done++;
                        res.status = ST_PIXEL;
                    end else begin
                        res.status = (fr == ST_NEED_BYTE) ? ST_NEED_BYTE : ST_ENDED;
                    end
                end
            end
            default: res.status = ST_REFUSED;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Code stream encoder
    // ------------------------------------------------------------------
    function automatic void enc_begin(input int unsigned root);
        enc_root  = root;
        enc_clear = 1 << root;
        enc_width = root + 1;
        enc_next  = enc_clear + 2;
        enc_live  = 1'b0;
        enc_acc   = '0;
        enc_bits  = 0;
        stream_bytes.delete();
    endfunction

    function automatic void enc_code(input int unsigned code);
        enc_acc  = enc_acc | (code << enc_bits);
        enc_bits = enc_bits + enc_width;
        while (enc_bits >= 8) begin
            stream_bytes.push_back(enc_acc[7:0]);
            enc_acc  = enc_acc >> 8;
            enc_bits = enc_bits - 8;
        end
        if (code == enc_clear) begin
            enc_width = enc_root + 1;
            enc_next  = enc_clear + 2;
            enc_live  = 1'b0;
        end else if (code != enc_clear + 1 && code <= enc_next) begin
            if (!enc_live) begin
                enc_live = (code < enc_clear);
            end else if (enc_next < TABLE_DEPTH) begin
                enc_next++;
                if ((enc_next & ((1 << enc_width) - 1)) == 0
                        && enc_next < TABLE_DEPTH && enc_width < MAX_WIDTH)
                    enc_width++;
            end
        end
    endfunction

    function automatic void enc_flush();
        logic [31:0] pad;
        logic [7:0]  tail;
        if (enc_bits > 0) begin
            pad  = $urandom;
            tail = enc_acc[7:0] | (pad[7:0] << enc_bits);
            stream_bytes.push_back(tail);
        end
    endfunction

    function automatic int unsigned pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enc_live) return (r < 5) ? enc_clear : $urandom_range(0, enc_clear - 1);
        if (r < 4) return enc_clear;
        if (r < 20 && enc_next < TABLE_DEPTH) return enc_next;
        if (r < 60 || enc_next == enc_clear + 2) return $urandom_range(0, enc_clear - 1);
        return $urandom_range(enc_clear + 2, enc_next - 1);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [PIX_W-1:0] data,
                             input logic fin, output t_status answer);
        decode_result_t res;
        i_valid      <= 1'b1;
        i_op         <= op;
        i_data_byte  <= data;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = decode_item(op, data, fin);
        owed_answers.push_back(res);
        answer = res.status;
        items_sent++;
        // Valid stays high inside a burst; the next beat reuses it.
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (owed_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOTAL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROOT_BITS) root_cfg = val[WIDTH_W-1:0];
        else if (idx == CFG_TOTAL_PIXELS) total_cfg = val;
        @(posedge i_clk);
    endtask

    task automatic set_image(input logic [WIDTH_W-1:0] root, input logic [TOTAL_W-1:0] total);
        t_status answer;
        wait_drained();
        write_reg(CFG_ROOT_BITS, {20'($urandom), root});
        write_reg(CFG_TOTAL_PIXELS, total);
        send_item(OP_START, $urandom, $urandom, answer);
    endtask

    // Feeds the packed stream, pushing on a byte request or at random (more
    // often with room), until the image completes, stops or the bytes run out.
    task automatic run_stream(input logic final_flag);
        t_status answer;
        bit      done;
        answer = ST_STARTED;
        done   = 1'b0;
        while (!done) begin
            if (stream_bytes.size() != 0 && (answer == ST_NEED_BYTE
                    || $urandom_range(0, 7) == 0
                    || (acc_count <= ACC_LIMIT && $urandom_range(0, 2) == 0))) begin
                send_item(OP_PUSH, stream_bytes[0], final_flag && stream_bytes.size() == 1,
                          answer);
                if (answer == ST_ACCEPTED) void'(stream_bytes.pop_front());
            end else begin
                send_item(OP_PULL, $urandom, $urandom, answer);
                done = (answer == ST_COMPLETE || answer == ST_ENDED
                        || (answer == ST_NEED_BYTE && stream_bytes.size() == 0));
            end
        end
        stream_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        t_status answer;
        send_item(OP_PULL, 8'h00, 1'b0, answer);
        send_item(OP_RESERVED, 8'hff, 1'b1, answer);
    endtask

    task automatic test_repeat_code_and_complete();
        set_image(4'd8, 24'd4);
        enc_begin(8);
        enc_code(256);
        enc_code(255);
        enc_code(258);
        enc_code(65);
        enc_code(257);
        enc_flush();
        run_stream(1'b1);
    endtask

    task automatic test_accumulator_full();
        t_status answer;
        wait_drained();
        send_item(OP_START, 8'h00, 1'b0, answer);
        repeat (4) send_item(OP_PUSH, $urandom, 1'b0, answer);
    endtask

    task automatic test_bad_first_code();
        t_status answer;
        set_image(4'd2, 24'hffffff);
        enc_begin(2);
        enc_code(6);
        enc_flush();
        run_stream(1'b1);
        send_item(OP_PULL, 8'h00, 1'b0, answer);
        send_item(OP_PUSH, 8'h5a, 1'b0, answer);
    endtask

    task automatic test_input_exhausted();
        set_image(4'd3, 24'd1000);
        enc_begin(3);
        enc_code(8);
        enc_code(3);
        enc_code(5);
        enc_code(11);
        enc_flush();
        run_stream(1'b1);
    endtask

    // Fills all table entries with root 2, then keeps decoding at 12 bits.
    task automatic test_full_dictionary();
        set_image(4'd2, 24'hffffff);
        enc_begin(2);
        enc_code(enc_clear);
        enc_code($urandom_range(0, 3));
        while (enc_next < TABLE_DEPTH) enc_code($urandom_range(0, 3));
        repeat (3) enc_code($urandom_range(enc_clear + 2, TABLE_DEPTH - 1));
        enc_code($urandom_range(0, 3));
        enc_code(enc_clear + 1);
        enc_flush();
        run_stream(1'b1);
    endtask

    task automatic random_image();
        logic [WIDTH_W-1:0] root;
        logic [TOTAL_W-1:0] total;
        t_status            answer;
        int unsigned        kind;
        root = ($urandom_range(0, 4) == 0) ? WIDTH_W'($urandom) : WIDTH_W'($urandom_range(2, 8));
        case ($urandom_range(0, 9))
            0:       total = '0;
            1:       total = 24'hffffff;
            2, 3:    total = $urandom_range(1, 6);
            default: total = $urandom_range(10, 200);
        endcase
        set_image(root, total);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(4, 20))
                send_item(2'($urandom), $urandom, $urandom_range(0, 7) == 0, answer);
        end else begin
            enc_begin(clamp_root(root));
            if ($urandom_range(0, 1) == 1) enc_code(enc_clear);
            repeat ($urandom_range(2, 16)) enc_code(pick_code());
            if (kind == 1) begin
                // Broken stream: an end code, a code past the dictionary,
                // or a first code that is not a root symbol.
                case ($urandom_range(0, 2))
                    0: enc_code(enc_clear + 1);
                    1: begin
                        if (enc_next + 1 < (1 << enc_width))
                            enc_code($urandom_range(enc_next + 1, (1 << enc_width) - 1));
                        else
                            enc_code(enc_clear + 1);
                    end
                    default: begin
                        enc_code(enc_clear);
                        enc_code($urandom_range(enc_clear + 2, (1 << enc_width) - 1));
                    end
                endcase
                repeat (2) enc_code($urandom_range(0, enc_clear - 1));
            end else if ($urandom_range(0, 1) == 1) begin
                enc_code(enc_clear + 1);
            end
            enc_flush();
            run_stream($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_PULL, $urandom, $urandom, answer);
                send_item(OP_PUSH, $urandom, $urandom, answer);
            end
        end
    endtask

    task automatic test_random_images();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) random_image();
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, checker, limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver switches at random between full rate, coin-flip, sparse
    // and long-stall patterns.
    initial begin : receiver
        int unsigned mode;
        int unsigned left;
        mode = 0;
        left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 1);
                2:       i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= (left % 12 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_beats
        decode_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_answers.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected beat: pixel %0d status %0d", o_pixel, o_status);
            end else begin
                want = owed_answers.pop_front();
                if (o_pixel !== want.pixel || o_status !== want.status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected pixel %0d status %0d, got pixel %0d status %0d",
                                 want.pixel, want.status, o_pixel, o_status);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("gif_lzw_decoder regression: fail");
        $finish;
    end

    initial begin
        error_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        root_cfg    = ROOT_RESET;
        total_cfg   = '0;
        start_image();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_op         <= OP_START;
        i_data_byte  <= '0;
        i_final_byte <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_ROOT_BITS;
        i_cfg_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_repeat_code_and_complete();
        test_accumulator_full();
        test_bad_first_code();
        test_input_exhausted();
        test_full_dictionary();
        test_random_images();
        wait_drained();

        if (error_count == 0) begin
            $display("gif_lzw_decoder regression: pass");
        end else begin
            $display("gif_lzw_decoder regression: fail");
        end
        $finish;
    end

endmodule
